@@ hw/rtl/bfsk_pkg.sv @@
// Shared types and constants of the Bloom filter unit.
package bfsk_pkg;

  localparam int unsigned MW = 13;  // width of the filter_bits register

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [0:0] REG_FILTER_BITS = 1'd0;
  localparam logic [0:0] REG_HASH_COUNT  = 1'd1;

  localparam logic [2:0] H_MUL  = 3'd0;
  localparam logic [2:0] H_SEED = 3'd1;
  localparam logic [2:0] H_DJB  = 3'd2;
  localparam logic [2:0] H_ROT  = 3'd3;
  localparam logic [2:0] H_SDBM = 3'd4;
  localparam logic [2:0] H_SFXM = 3'd5;
  localparam logic [2:0] H_SFXS = 3'd6;

  localparam logic [31:0] MUL_START = 32'd548957;
  localparam logic [31:0] MUL_STEP  = 32'd93683;
  localparam logic [31:0] SEED_B    = 32'd97;
  localparam logic [31:0] DJB_START = 32'd5381;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] key_byte;
    logic       last;
  } key_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       found;
    logic       too_long;
  } result_t;

  typedef struct packed {
    logic [0:0]    reg_index;
    logic [MW-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic        restart;
    logic        take;
    logic [7:0]  key_byte;
  } hash_ctl_t;

  typedef struct packed {
    logic          start;
    logic [31:0]   dividend;
    logic [MW-1:0] modulus;
  } mod_req_t;

endpackage

@@ hw/rtl/bfsk_chan_if.sv @@
// Valid/ready channel carrying one payload type.
interface bfsk_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/bfsk_mod_unit.sv @@
// Bit-serial restoring modulo unit, one dividend bit per cycle.
module bfsk_mod_unit import bfsk_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mod_req_t      req_i,
  output logic          done_o,
  output logic [MW-1:0] rem_o
);

  logic [31:0]   dvd_q, dvd_d;
  logic [MW-1:0] rem_q, rem_d;
  logic [MW-1:0] m_q, m_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [MW:0]   trial;

  always_comb begin
    trial  = {rem_q, dvd_q[31]};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    m_d    = m_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      m_d    = req_i.modulus;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, m_q}) begin
        rem_d = MW'(trial - {1'b0, m_q});
      end else begin
        rem_d = trial[MW-1:0];
      end
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    m_q   <= m_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ hw/rtl/bfsk_hash_acc.sv @@
// Per-byte string hash accumulators and decimal suffix values.
module bfsk_hash_acc import bfsk_pkg::*; #(
  parameter int unsigned MAX_KEY_LEN = 16,
  parameter int unsigned LW = $clog2(MAX_KEY_LEN + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hash_ctl_t                         ctl_i,
  output logic [4:0][31:0]                  acc_o,
  output logic [31:0]                       rot_len_o,
  output logic [LW-1:0]                     len_o,
  output logic [MAX_KEY_LEN-1:0][31:0]      sv_o,
  output logic                              full_o,
  output logic                              overlong_o
);

  logic [4:0][31:0]             acc_q, acc_d;
  logic [31:0]                  mul_q, mul_d;
  logic [LW-1:0]                len_q, len_d;
  logic [MAX_KEY_LEN-1:0][31:0] sv_q, sv_d;
  logic [MAX_KEY_LEN-1:0]       stop_q, stop_d;
  logic                         ovl_q, ovl_d;
  logic [31:0]                  c;
  logic [31:0]                  dig_val;
  logic                         dig;
  logic                         full;
  logic [63:0]                  rot_wide;
  logic [4:0]                   rot_amt;

  assign full    = (len_q == LW'(MAX_KEY_LEN));
  assign c       = {24'd0, ctl_i.key_byte};
  assign dig     = (ctl_i.key_byte >= 8'h30) && (ctl_i.key_byte <= 8'h39);
  assign dig_val = {24'd0, ctl_i.key_byte - 8'h30};

  always_comb begin
    acc_d  = acc_q;
    mul_d  = mul_q;
    len_d  = len_q;
    sv_d   = sv_q;
    stop_d = stop_q;
    ovl_d  = ovl_q;
    if (ctl_i.restart) begin
      // Only the djb2 accumulator starts nonzero.
      acc_d  = {32'd0, 32'd0, DJB_START, 32'd0, 32'd0};
      mul_d  = MUL_START;
      len_d  = '0;
      stop_d = '0;
      ovl_d  = 1'b0;
    end else if (ctl_i.take) begin
      if (full) begin
        ovl_d = 1'b1;
      end else begin
        acc_d[H_MUL]  = acc_q[H_MUL] * mul_q + c;
        mul_d         = mul_q * MUL_STEP;
        acc_d[H_SEED] = acc_q[H_SEED] * SEED_B + c;
        acc_d[H_DJB]  = (acc_q[H_DJB] << 5) + acc_q[H_DJB] + c;
        acc_d[H_ROT]  = {acc_q[H_ROT][26:0], acc_q[H_ROT][31:27]} ^ c;
        acc_d[H_SDBM] = (acc_q[H_SDBM] << 16) + (acc_q[H_SDBM] << 6)
                        - acc_q[H_SDBM] + c;
        for (int unsigned i = 1; i < MAX_KEY_LEN; i++) begin
          if (LW'(i) < len_q) begin
            if (!stop_q[i]) begin
              if (dig) begin
                sv_d[i] = (sv_q[i] << 3) + (sv_q[i] << 1) + dig_val;
              end else begin
                stop_d[i] = 1'b1;
              end
            end
          end else if (LW'(i) == len_q) begin
            sv_d[i]   = dig ? dig_val : 32'd0;
            stop_d[i] = !dig;
          end
        end
        len_d = len_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= {32'd0, 32'd0, DJB_START, 32'd0, 32'd0};
      mul_q  <= MUL_START;
      len_q  <= '0;
      stop_q <= '0;
      ovl_q  <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      mul_q  <= mul_d;
      len_q  <= len_d;
      stop_q <= stop_d;
      ovl_q  <= ovl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sv_q <= sv_d;
  end

  // Length mixed in for the rotate-xor hash: rotl(n, 5n mod 32).
  assign rot_amt  = 5'((len_q << 2) + len_q);
  assign rot_wide = {32'(len_q), 32'(len_q)} << rot_amt;

  assign acc_o      = acc_q;
  assign rot_len_o  = rot_wide[63:32];
  assign len_o      = len_q;
  assign sv_o       = sv_q;
  assign full_o     = full;
  assign overlong_o = ovl_q;

endmodule

@@ hw/rtl/bfsk_bit_store.sv @@
// Single-port bit memory holding the filter, registered read data.
module bfsk_bit_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic          wdata_i,
  output logic          rdata_o
);

  logic mem [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bloom_filter_string_keys_unit.sv @@
// Top level of the Bloom filter unit over streamed string keys.
//
// Channel   Dir  Payload                               Transaction
// key_i     in   command, key_byte, last               one key byte or a clear
// res_o     out  kind, found, too_long                 one insert/search/clear result
// cfg_i     in   reg_index, wdata                      one register write
//
// A key byte that is not last is taken while idle and leaves the unit idle.
// At the last byte each applied hash passes a setup state, the serial modulo
// unit and the store probe (read, then check). The suffix-modulo hash adds a
// modulo pass for every key byte after the first.
// After reset and after a clear command the store is swept, one bit a cycle,
// while no key byte is accepted.
// A finished result waits in the output register; the next key's bytes are
// taken meanwhile and only a second result stalls behind it.
module bloom_filter_string_keys_unit import bfsk_pkg::*; #(
  parameter int unsigned FILTER_SIZE = 4096,
  parameter int unsigned MAX_KEY_LEN = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfsk_chan_if.sink   key_i,
  bfsk_chan_if.source res_o,
  bfsk_chan_if.sink   cfg_i
);

  localparam int unsigned IW = $clog2(FILTER_SIZE);
  localparam int unsigned LW = $clog2(MAX_KEY_LEN + 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SETUP = 8'b0000_0100,
    S_SUFX  = 8'b0000_1000,
    S_MODW  = 8'b0001_0000,
    S_RD    = 8'b0010_0000,
    S_CHK   = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [MW-1:0] filter_bits_q;
  logic [2:0]    hash_count_q;
  logic [MW-1:0] modulus;

  // Sequencer state.
  logic [2:0]    k_q, k_d;
  logic [LW-1:0] i_q, i_d;
  logic [31:0]   sum_q, sum_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] clr_q, clr_d;
  logic          to_sum_q, to_sum_d;
  logic [1:0]    cmd_q, cmd_d;
  logic          found_q, found_d;
  logic          long_q, long_d;
  logic          clr_resp_q, clr_resp_d;

  // Output register.
  logic          out_valid_q, out_valid_d;
  result_t       out_q, out_d;

  // Submodule connections.
  hash_ctl_t                    hctl;
  logic [4:0][31:0]             acc;
  logic [31:0]                  rot_len;
  logic [LW-1:0]                len;
  logic [MAX_KEY_LEN-1:0][31:0] sv;
  logic                         len_full;
  logic                         overlong;
  mod_req_t                     mreq;
  logic                         mod_done;
  logic [MW-1:0]                mod_rem;
  logic                         st_we;
  logic [IW-1:0]                st_addr;
  logic                         st_rdata;
  logic                         key_acc;
  logic [31:0]                  sv_sel;

  bfsk_hash_acc #(.MAX_KEY_LEN(MAX_KEY_LEN), .LW(LW)) u_hash (
    .clk_i, .rst_ni, .ctl_i(hctl), .acc_o(acc), .rot_len_o(rot_len),
    .len_o(len), .sv_o(sv), .full_o(len_full), .overlong_o(overlong)
  );

  bfsk_mod_unit u_mod (
    .clk_i, .rst_ni, .req_i(mreq), .done_o(mod_done), .rem_o(mod_rem)
  );

  bfsk_bit_store #(.DEPTH(FILTER_SIZE), .AW(IW)) u_store (
    .clk_i, .we_i(st_we), .addr_i(st_addr), .wdata_i(state_q != S_CLEAR),
    .rdata_o(st_rdata)
  );

  // Modulus in use: zero counts as one, anything above the store size is clamped.
  always_comb begin
    if (filter_bits_q == '0) begin
      modulus = MW'(1);
    end else if (32'(filter_bits_q) > 32'(FILTER_SIZE)) begin
      modulus = MW'(FILTER_SIZE);
    end else begin
      modulus = filter_bits_q;
    end
  end

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_bits_q <= MW'(4096);
      hash_count_q  <= 3'd3;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        REG_FILTER_BITS: filter_bits_q <= cfg_i.data.wdata;
        REG_HASH_COUNT:  hash_count_q  <= cfg_i.data.wdata[2:0];
        default: ;
      endcase
    end
  end

  assign key_i.ready = (state_q == S_IDLE);
  assign key_acc     = key_i.valid && key_i.ready;
  assign sv_sel      = sv[i_q[$clog2(MAX_KEY_LEN)-1:0]];

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    i_d         = i_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    clr_d       = clr_q;
    to_sum_d    = to_sum_q;
    cmd_d       = cmd_q;
    found_d     = found_q;
    long_d      = long_q;
    clr_resp_d  = clr_resp_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_d       = out_q;
    hctl        = '{restart: 1'b0, take: 1'b0, key_byte: key_i.data.key_byte};
    mreq        = '{start: 1'b0, dividend: 32'd0, modulus: modulus};
    st_we       = 1'b0;
    st_addr     = idx_q;

    case (state_q)
      S_CLEAR: begin
        st_we   = 1'b1;
        st_addr = clr_q;
        clr_d   = clr_q + IW'(1);
        if (clr_q == IW'(FILTER_SIZE - 1)) begin
          state_d = clr_resp_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (key_acc) begin
          case (key_i.data.command)
            CMD_CLEAR: begin
              hctl.restart = 1'b1;
              clr_d        = '0;
              clr_resp_d   = 1'b1;
              cmd_d        = KIND_CLEAR;
              found_d      = 1'b0;
              long_d       = 1'b0;
              state_d      = S_CLEAR;
            end
            CMD_INSERT, CMD_SEARCH: begin
              hctl.take = 1'b1;
              if (key_i.data.last) begin
                cmd_d   = key_i.data.command;
                k_d     = '0;
                found_d = 1'b1;
                if (overlong || len_full) begin
                  long_d  = 1'b1;
                  found_d = 1'b0;
                  state_d = S_RESP;
                end else begin
                  long_d  = 1'b0;
                  state_d = S_SETUP;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        if (k_q >= hash_count_q) begin
          state_d = S_RESP;
        end else begin
          to_sum_d = 1'b0;
          state_d  = S_MODW;
          mreq.start = 1'b1;
          case (k_q)
            H_MUL, H_SEED, H_DJB, H_SDBM: mreq.dividend = acc[k_q];
            H_ROT: mreq.dividend = acc[H_ROT] ^ rot_len;
            default: begin
              mreq.start = 1'b0;
              sum_d      = '0;
              i_d        = LW'(1);
              state_d    = S_SUFX;
            end
          endcase
        end
      end
      S_SUFX: begin
        if (i_q >= len) begin
          mreq.start    = 1'b1;
          mreq.dividend = sum_q;
          to_sum_d      = 1'b0;
          state_d       = S_MODW;
        end else if (k_q == H_SFXM) begin
          mreq.start    = 1'b1;
          mreq.dividend = (sv_sel << 2) + sv_sel
                          + 32'((32'(len) << 3) - 32'(len));
          to_sum_d      = 1'b1;
          state_d       = S_MODW;
        end else begin
          sum_d = sum_q + sv_sel;
          i_d   = i_q + LW'(1);
        end
      end
      S_MODW: begin
        if (mod_done) begin
          if (to_sum_q) begin
            sum_d   = sum_q + 32'(mod_rem);
            i_d     = i_q + LW'(1);
            state_d = S_SUFX;
          end else begin
            idx_d   = IW'(mod_rem);
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        k_d     = k_q + 3'd1;
        state_d = S_SETUP;
        if (cmd_q == CMD_INSERT) begin
          st_we = 1'b1;
        end else if (!st_rdata) begin
          found_d = 1'b0;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d    = 1'b1;
          out_d.kind     = cmd_q;
          out_d.found    = (cmd_q == CMD_SEARCH) && found_q && !long_q;
          out_d.too_long = long_q;
          hctl.restart   = 1'b1;
          clr_resp_d     = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      clr_resp_q  <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      i_q         <= '0;
      to_sum_q    <= 1'b0;
      cmd_q       <= CMD_INSERT;
      found_q     <= 1'b0;
      long_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_resp_q  <= clr_resp_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      i_q         <= i_d;
      to_sum_q    <= to_sum_d;
      cmd_q       <= cmd_d;
      found_q     <= found_d;
      long_q      <= long_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    idx_q <= idx_d;
    out_q <= out_d;
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // A search never writes the store; only inserts and the sweep do.
  a_no_search_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_we && state_q == S_CHK) |-> (cmd_q == CMD_INSERT))
    else $error("store written during a search");

  // A probe only happens for a hash that is actually enabled.
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (k_q < hash_count_q))
    else $error("probe beyond hash count");

  // An overlong key never reports a hit.
  a_long_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.too_long) |-> !res_o.data.found)
    else $error("overlong key reported found");

  // The modulo unit is only started from a state that then waits for it.
  a_mod_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.start |=> (state_q == S_MODW))
    else $error("modulo started without waiting");

endmodule

@@ verif/bfsk_result_checker.sv @@
// Result predictor and checker for the Bloom filter unit.
`timescale 1ns / 100ps

module bfsk_result_checker import bfsk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        key_valid_i,
  input  logic        key_ready_i,
  input  key_item_t   key_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  result_t     res_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  cfg_item_t   cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned NBITS  = 4096;
  localparam int unsigned KEYMAX = 16;

  logic [NBITS-1:0] bit_store;
  logic [31:0]      acc [5];
  logic [31:0]      mul_run;
  logic [31:0]      key_len;
  logic [31:0]      sfx_val [KEYMAX];
  logic             sfx_stop [KEYMAX];
  logic             overlong;
  logic [MW-1:0]    filter_bits;
  logic [2:0]       hash_count;
  result_t          expected_results [$];
  int unsigned      fails;
  int unsigned      queued;

  assign fail_count_o = fails;
  assign pending_o    = queued;

  function automatic logic [31:0] rotl(logic [31:0] v, logic [31:0] s);
    logic [4:0] sh;
    sh = s[4:0];
    return (sh == 0) ? v : ((v << sh) | (v >> (6'd32 - sh)));
  endfunction

  function automatic void key_restart();
    acc[0] = 0; acc[1] = 0; acc[2] = DJB_START; acc[3] = 0; acc[4] = 0;
    mul_run  = MUL_START;
    key_len  = 0;
    overlong = 1'b0;
    for (int i = 0; i < KEYMAX; i++) begin
      sfx_val[i]  = 0;
      sfx_stop[i] = 1'b0;
    end
  endfunction

  // Folds one key byte into the running hashes and the suffix values.
  task automatic hash_take_byte(logic [7:0] c);
    logic        dig;
    logic [31:0] d;
    logic [31:0] p;
    dig = (c >= 8'h30) && (c <= 8'h39);
    d   = {24'd0, c} - 32'h30;
    p   = key_len;
    if (p >= KEYMAX) begin
      overlong = 1'b1;
    end else begin
      acc[0]  = acc[0] * mul_run + c;
      mul_run = mul_run * MUL_STEP;
      acc[1]  = acc[1] * SEED_B + c;
      acc[2]  = acc[2] * 32'd33 + c;
      acc[3]  = rotl(acc[3], 32'd5) ^ {24'd0, c};
      acc[4]  = acc[4] * 32'd65599 + c;
      for (int i = 1; i < p; i++) begin
        if (!sfx_stop[i]) begin
          if (dig) sfx_val[i] = sfx_val[i] * 32'd10 + d;
          else sfx_stop[i] = 1'b1;
        end
      end
      if (p >= 1) begin
        sfx_val[p]  = dig ? d : 32'd0;
        sfx_stop[p] = !dig;
      end
      key_len = p + 1;
    end
  endtask

  function automatic logic [31:0] bit_index(logic [2:0] which, logic [31:0] m);
    logic [31:0] s;
    s = 0;
    case (which)
      H_MUL, H_SEED, H_DJB, H_SDBM: return acc[which] % m;
      H_ROT: return (acc[3] ^ rotl(key_len, 32'd5 * key_len)) % m;
      default: begin
        for (int i = 1; i < key_len && i < KEYMAX; i++) begin
          if (which == H_SFXM) s = s + (32'd5 * sfx_val[i] + 32'd7 * key_len) % m;
          else s = s + sfx_val[i];
        end
        return s % m;
      end
    endcase
  endfunction

  // Completes a key: applies the hashes to the store and forms the result.
  function automatic result_t key_finish(logic [1:0] cmd);
    result_t     r;
    logic [31:0] m;
    logic [31:0] idx;
    logic        hit;
    r.kind = cmd; r.found = 1'b0; r.too_long = 1'b0;
    hit = 1'b1;
    if (overlong) begin
      r.too_long = 1'b1;
    end else begin
      m = (filter_bits == 0) ? 32'd1 :
          (32'(filter_bits) > NBITS) ? NBITS : 32'(filter_bits);
      for (int k = 0; k < hash_count; k++) begin
        if (hit) begin
          idx = bit_index(k[2:0], m);
          if (cmd == CMD_INSERT) bit_store[idx] = 1'b1;
          else if (!bit_store[idx]) hit = 1'b0;
        end
      end
      r.found = (cmd == CMD_SEARCH) ? hit : 1'b0;
    end
    key_restart();
    return r;
  endfunction

  task automatic report(string what, logic [3:0] exp_v, logic [3:0] got_v);
    $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
    fails++;
  endtask

  initial begin
    fails = 0;
    queued = 0;
    bit_store = '0;
    filter_bits = 13'd4096;
    hash_count = 3'd3;
    key_restart();
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_data_i.reg_index == REG_FILTER_BITS) filter_bits = cfg_data_i.wdata;
        else hash_count = cfg_data_i.wdata[2:0];
      end
      if (key_valid_i && key_ready_i) begin
        if (key_data_i.command == CMD_CLEAR) begin
          bit_store = '0;
          key_restart();
          expected_results.push_back('{kind: KIND_CLEAR, found: 1'b0, too_long: 1'b0});
        end else if (key_data_i.command != CMD_NONE) begin
          hash_take_byte(key_data_i.key_byte);
          if (key_data_i.last)
            expected_results.push_back(key_finish(key_data_i.command));
        end
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", 4'd0, {res_data_i});
        end else begin
          want = expected_results.pop_front();
          if (want.kind != res_data_i.kind)
            report("kind", 4'(want.kind), 4'(res_data_i.kind));
          if (want.found != res_data_i.found)
            report("found", 4'(want.found), 4'(res_data_i.found));
          if (want.too_long != res_data_i.too_long)
            report("too_long", 4'(want.too_long), 4'(res_data_i.too_long));
        end
      end
      queued = expected_results.size();
    end
  end

endmodule

@@ verif/tb_bloom_filter_string_keys_unit.sv @@
// Stimulus and verdict for the Bloom filter unit over streamed string keys.
`timescale 1ns / 100ps

module tb_bloom_filter_string_keys_unit;
  import bfsk_pkg::*;

  logic clk_i;
  logic rst_ni;

  bfsk_chan_if #(.T(key_item_t)) key_ch ();
  bfsk_chan_if #(.T(result_t))   res_ch ();
  bfsk_chan_if #(.T(cfg_item_t)) cfg_ch ();

  int unsigned fail_count;
  int unsigned pending;

  // Idling is switched off for the last phase of the run.
  logic        idle_en;
  // While set, the result side holds off so that the unit backs up.
  logic        hold_off;
  int unsigned bytes_sent;

  // Up to 64 short keys inserted so far, kept so that searches can hit as well as miss.
  logic [7:0]  pool [64][20];
  int unsigned pool_len [64];
  int unsigned pool_fill;

  bloom_filter_string_keys_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  bfsk_result_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_valid_i  (key_ch.valid),
    .key_ready_i  (key_ch.ready),
    .key_data_i   (key_ch.data),
    .res_valid_i  (res_ch.valid),
    .res_ready_i  (res_ch.ready),
    .res_data_i   (res_ch.data),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_ready_i  (cfg_ch.ready),
    .cfg_data_i   (cfg_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The run is cut off long after the slowest correct run would have ended.
  initial begin
    #20ms;
    $display("bloom_filter_string_keys_unit verification failed");
    $finish;
  end

  // Result side: random bursts of stall, a long hold-off when requested.
  initial begin
    int unsigned gap;
    gap = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        res_ch.ready = 1'b0;
      end else if (gap > 0) begin
        res_ch.ready = 1'b0;
        gap--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        res_ch.ready = 1'b0;
        gap = $urandom_range(1, 15) - 1;
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  // Once the full-filter phase is under way, the result side stops for a long stretch
  // while key bytes keep coming, so the output fills and the input stalls.
  initial begin
    hold_off = 1'b0;
    wait (bytes_sent >= 450);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (3000) @(negedge clk_i);
    hold_off = 1'b0;
  end

  // Sends one key transaction; valid stays high into the next one unless a gap falls.
  task automatic send_item(logic [1:0] cmd, logic [7:0] kb, logic last);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      key_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    key_ch.valid = 1'b1;
    key_ch.data  = '{command: cmd, key_byte: kb, last: last};
    do @(posedge clk_i); while (!key_ch.ready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Waits for every pending result, then waits out the store sweep that a clear may start.
  task automatic drain();
    key_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (5000) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [MW-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = '{reg_index: idx, wdata: value};
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [7:0] rand_char();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 8'(8'h30 + $urandom_range(0, 9));
    if (pick < 7) return 8'(8'h61 + $urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  // One key, mostly well formed; now and then broken by a stray command.
  task automatic send_key();
    logic [1:0]  cmd;
    logic [7:0]  kb [20];
    int unsigned len;
    int unsigned slot;
    bit          reuse;
    cmd = ($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_SEARCH;
    reuse = (cmd == CMD_SEARCH) && (pool_fill > 0) && ($urandom_range(0, 1) == 0);
    if (reuse) begin
      slot = $urandom_range(0, pool_fill - 1);
      len = pool_len[slot];
      for (int i = 0; i < len; i++) kb[i] = pool[slot][i];
    end else begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) kb[i] = rand_char();
    end
    if (cmd == CMD_INSERT && len <= 16) begin
      if (pool_fill < 64) begin
        slot = pool_fill;
        pool_fill++;
      end else begin
        slot = $urandom_range(0, 63);
      end
      pool_len[slot] = len;
      for (int i = 0; i < len; i++) pool[slot][i] = kb[i];
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 40) == 0)
        send_item(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if (i + 1 == len) send_item(cmd, kb[i], 1'b1);
      else if ($urandom_range(0, 30) == 0) send_item(~cmd & 2'b01, kb[i], 1'b0);
      else send_item(cmd, kb[i], 1'b0);
    end
  endtask

  task automatic random_phase(int unsigned bytes_goal);
    while (bytes_sent < bytes_goal) begin
      if ($urandom_range(0, 60) == 0)
        send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else send_key();
    end
  endtask

  initial begin
    int unsigned waited;
    rst_ni       = 1'b0;
    idle_en      = 1'b1;
    bytes_sent   = 0;
    pool_fill    = 0;
    key_ch.valid = 1'b0;
    key_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at reset settings: extreme bytes, a zero byte inside a key,
    // digit runs, a command change on the last byte, a clear mid-key, an
    // ignored command and an overlong key.
    send_item(CMD_INSERT, 8'h00, 1'b0);
    send_item(CMD_INSERT, 8'hff, 1'b1);
    send_item(CMD_SEARCH, 8'h00, 1'b0);
    send_item(CMD_SEARCH, 8'hff, 1'b1);
    send_item(CMD_INSERT, "7", 1'b1);
    send_item(CMD_SEARCH, "k", 1'b0);
    send_item(CMD_SEARCH, "1", 1'b0);
    send_item(CMD_SEARCH, "2", 1'b0);
    send_item(CMD_SEARCH, "a", 1'b0);
    send_item(CMD_INSERT, "9", 1'b1);
    send_item(CMD_NONE, 8'h55, 1'b1);
    send_item(CMD_INSERT, "q", 1'b0);
    send_item(CMD_CLEAR, 8'h00, 1'b0);
    send_item(CMD_SEARCH, "7", 1'b1);
    for (int i = 0; i < 17; i++) send_item(CMD_INSERT, 8'("0" + (i % 10)), i == 16);
    drain();

    // Smallest filter with every hash: all indices collapse onto one bit.
    write_reg(REG_FILTER_BITS, 13'd1);
    write_reg(REG_HASH_COUNT, 3'd7);
    random_phase(400);
    drain();

    // Full filter, every hash; the long hold-off falls in here.
    write_reg(REG_FILTER_BITS, 13'd4096);
    random_phase(800);
    drain();

    // Zero hashes makes every search of a key that is not overlong answer found; zero and oversize widths are clamped.
    write_reg(REG_FILTER_BITS, 13'd0);
    write_reg(REG_HASH_COUNT, 3'd0);
    random_phase(1000);
    drain();
    write_reg(REG_FILTER_BITS, 13'h1fff);
    write_reg(REG_HASH_COUNT, 3'd5);
    random_phase(1250);
    drain();

    // Small random width with random hash count, then a final phase without idling.
    write_reg(REG_FILTER_BITS, MW'($urandom_range(2, 97)));
    write_reg(REG_HASH_COUNT, 3'($urandom_range(1, 7)));
    random_phase(1550);
    drain();
    write_reg(REG_FILTER_BITS, MW'($urandom_range(1, 4096)));
    write_reg(REG_HASH_COUNT, 3'($urandom_range(0, 7)));
    idle_en = 1'b0;
    random_phase(1880);
    key_ch.valid = 1'b0;

    waited = 0;
    while (pending != 0 && waited < 200000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (1000) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("bloom_filter_string_keys_unit verification clean");
    end else begin
      $display("bloom_filter_string_keys_unit verification failed");
    end
    $finish;
  end

endmodule

@@ bloom_filter_string_keys_unit.f @@
hw/rtl/bfsk_pkg.sv
hw/rtl/bfsk_chan_if.sv
hw/rtl/bfsk_mod_unit.sv
hw/rtl/bfsk_hash_acc.sv
hw/rtl/bfsk_bit_store.sv
hw/rtl/bloom_filter_string_keys_unit.sv
verif/bfsk_result_checker.sv
verif/tb_bloom_filter_string_keys_unit.sv
